// ----- hw/rtl/u8d_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-32 decoder.
package u8d_pkg;

    typedef enum logic [1:0] {
        PH_WRITING  = 2'd0,
        PH_COUNTING = 2'd1,
        PH_DISCARD  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_CHAR      = 3'd0,
        ST_CHAR_DONE = 3'd1,
        ST_ERROR     = 3'd2,
        ST_FULL      = 3'd3,
        ST_REQ_LEN   = 3'd4
    } status_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_AT_NUL     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_LIMIT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_WHEN_FULL = 2'd2;

    localparam logic [7:0] LEAD_ASCII_END = 8'h80;
    localparam logic [7:0] LEAD_2_MIN     = 8'hC2;
    localparam logic [7:0] LEAD_3_MIN     = 8'hE0;
    localparam logic [7:0] LEAD_4_MIN     = 8'hF0;
    localparam logic [7:0] LEAD_4_MAX     = 8'hF4;

    // Range checks on (lead << 6) + second byte
    localparam logic [13:0] T3_MIN      = 14'h38A0;
    localparam logic [13:0] T3_SURR_LO  = 14'h3BE0;
    localparam logic [13:0] T3_SURR_HI  = 14'h3BFF;
    localparam logic [13:0] T4_MIN      = 14'h3C90;
    localparam logic [13:0] T4_MAX      = 14'h3D8F;

    typedef struct packed {
        logic        stop_at_nul;
        logic [31:0] out_limit;
        logic        count_when_full;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [20:0] code_point;
        status_t     status;
        logic [32:0] count;
        logic [31:0] offset;
        logic        done_res;
    } res_t;

endpackage

// ----- hw/rtl/u8d_ifs.sv -----
// Channel interfaces: byte input, decoded output and configuration write.
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  status;
    logic [32:0] count;
    logic [31:0] offset;
    logic        done_res;

    modport source (output valid, output code_point, output status, output count,
                    output offset, output done_res, input ready);
    modport sink   (input valid, input code_point, input status, input count,
                    input offset, input done_res, output ready);
endinterface

interface u8d_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/u8d_core.sv -----
// Decoder state and the per-byte decode, validation and counting logic.
module u8d_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  u8d_pkg::item_t item,
    input  u8d_pkg::cfg_t  cfg,
    output u8d_pkg::res_t  res
);
    import u8d_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int WB = (COUNT_BITS < 64) ? COUNT_BITS + 1 : 64;
    localparam int MW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    phase_t          phase_reg, phase_next;
    logic [1:0]      pend_reg, pend_next;
    logic [1:0]      lead_reg, lead_next;
    logic [20:0]     acc_reg, acc_next;
    logic [CB-1:0]   seq_reg, seq_next;
    logic [CB-1:0]   off_reg, off_next;
    logic [CB-1:0]   cw_reg, cw_next;
    logic [WB-1:0]   cc_reg, cc_next;
    logic [CB-1:0]   resume_reg, resume_next;

    logic [7:0]      b;
    logic            ends;
    logic            discard;
    logic            pend_z;
    logic [CB-1:0]   seq_eff;
    logic [CB-1:0]   off_inc;
    logic [13:0]     t3;
    logic [13:0]     t4;
    logic            dec_err;
    logic            have;
    logic [20:0]     cp;
    logic [1:0]      pend_d;
    logic [1:0]      lead_d;
    logic [20:0]     acc_d;
    logic            writing;
    logic            full_before;
    logic            do_write;
    logic [CB-1:0]   cw_inc;
    logic            hits;
    logic [WB-1:0]   cc_base;
    logic [WB-1:0]   cc_inc;
    logic [CB-1:0]   resume_eff;

    assign b        = item.in_byte;
    assign ends     = cfg.stop_at_nul ? (b == 8'h00) : item.is_last;
    assign discard  = (phase_reg != PH_WRITING) && (phase_reg != PH_COUNTING);
    assign pend_z   = (pend_reg == 2'd0);
    assign seq_eff  = pend_z ? off_reg : seq_reg;
    assign off_inc  = off_reg + CB'(1);
    assign t3       = {(8'hE0 | acc_reg[7:0]), 6'b0} + {6'b0, b};
    assign t4       = {(8'hF0 | acc_reg[7:0]), 6'b0} + {6'b0, b};

    assign writing     = (phase_reg == PH_WRITING);
    assign full_before = MW'(cw_reg) >= MW'(cfg.out_limit);
    assign do_write    = writing && !full_before;
    assign cw_inc      = cw_reg + CB'(1);
    assign hits        = MW'(cw_inc) == MW'(cfg.out_limit);
    assign cc_base     = writing ? WB'(cw_reg) : cc_reg;
    assign cc_inc      = cc_base + WB'(1);
    assign resume_eff  = writing ? seq_eff : resume_reg;

    // Byte classification and sequence assembly
    always_comb
    begin
        dec_err = 1'b0;
        have    = 1'b0;
        cp      = '0;
        pend_d  = pend_reg;
        lead_d  = lead_reg;
        acc_d   = acc_reg;
        if (pend_z)
        begin
            if (b < LEAD_ASCII_END)
            begin
                cp   = {13'b0, b};
                have = 1'b1;
            end
            else if (b < LEAD_2_MIN)
            begin
                dec_err = 1'b1;
            end
            else if (b < LEAD_3_MIN)
            begin
                lead_d = 2'd1;
                pend_d = 2'd1;
                acc_d  = {16'b0, b[4:0]};
            end
            else if (b < LEAD_4_MIN)
            begin
                lead_d = 2'd2;
                pend_d = 2'd2;
                acc_d  = {17'b0, b[3:0]};
            end
            else if (b <= LEAD_4_MAX)
            begin
                lead_d = 2'd3;
                pend_d = 2'd3;
                acc_d  = {18'b0, b[2:0]};
            end
            else
            begin
                dec_err = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            dec_err = 1'b1;
        end
        else
        begin
            // first continuation of a 3- or 4-byte form: reject overlong,
            // surrogate and out-of-range values
            if (pend_reg == lead_reg && lead_reg >= 2'd2)
            begin
                if (lead_reg == 2'd2)
                begin
                    if (t3 < T3_MIN || (t3 >= T3_SURR_LO && t3 <= T3_SURR_HI))
                        dec_err = 1'b1;
                end
                else
                begin
                    if (t4 < T4_MIN || t4 > T4_MAX)
                        dec_err = 1'b1;
                end
            end
            if (!dec_err)
            begin
                acc_d  = {acc_reg[14:0], b[5:0]};
                pend_d = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    cp   = {acc_reg[14:0], b[5:0]};
                    have = 1'b1;
                end
            end
        end
        if (!dec_err && !have && ends)
            dec_err = 1'b1;
    end

    // Next state
    always_comb
    begin
        logic clear;
        clear       = 1'b0;
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        lead_next   = lead_reg;
        acc_next    = acc_reg;
        seq_next    = seq_reg;
        off_next    = off_reg;
        cw_next     = cw_reg;
        cc_next     = cc_reg;
        resume_next = resume_reg;
        if (step)
        begin
            if (discard)
            begin
                clear = ends;
            end
            else
            begin
                off_next = off_inc;
                seq_next = seq_eff;
                if (dec_err)
                begin
                    clear      = ends;
                    phase_next = PH_DISCARD;
                    pend_next  = 2'd0;
                end
                else if (!have)
                begin
                    pend_next = pend_d;
                    lead_next = lead_d;
                    acc_next  = acc_d;
                end
                else
                begin
                    pend_next = 2'd0;
                    lead_next = 2'd0;
                    acc_next  = '0;
                    if (do_write)
                    begin
                        cw_next = cw_inc;
                        clear   = ends;
                        if (hits)
                        begin
                            if (cfg.count_when_full)
                            begin
                                phase_next  = PH_COUNTING;
                                resume_next = off_inc;
                                cc_next     = WB'(cw_inc);
                            end
                            else
                            begin
                                phase_next = PH_DISCARD;
                            end
                        end
                    end
                    else
                    begin
                        phase_next  = PH_COUNTING;
                        resume_next = resume_eff;
                        cc_next     = cc_inc;
                        clear       = ends;
                    end
                end
            end
        end
        if (clear)
        begin
            phase_next  = PH_WRITING;
            pend_next   = '0;
            lead_next   = '0;
            acc_next    = '0;
            seq_next    = '0;
            off_next    = '0;
            cw_next     = '0;
            cc_next     = '0;
            resume_next = '0;
        end
    end

    // Result of this byte
    always_comb
    begin
        res.valid      = 1'b0;
        res.code_point = '0;
        res.status     = ST_CHAR;
        res.count      = '0;
        res.offset     = '0;
        res.done_res   = 1'b0;
        if (!discard)
        begin
            if (dec_err)
            begin
                res.valid    = 1'b1;
                res.status   = ST_ERROR;
                res.count    = 33'(cw_reg);
                res.offset   = 32'(seq_eff);
                res.done_res = ends;
            end
            else if (have && do_write)
            begin
                res.valid      = 1'b1;
                res.code_point = cp;
                res.count      = 33'(cw_inc);
                res.offset     = 32'(off_inc);
                if (ends)
                begin
                    res.status   = ST_CHAR_DONE;
                    res.done_res = 1'b1;
                end
                else if (hits && !cfg.count_when_full)
                begin
                    res.status = ST_FULL;
                    res.count  = 33'(cfg.out_limit) + 33'd1;
                end
            end
            else if (have && ends)
            begin
                res.valid    = 1'b1;
                res.status   = ST_REQ_LEN;
                res.count    = 33'(cc_inc);
                res.offset   = 32'(resume_eff);
                res.done_res = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WRITING;
            pend_reg   <= '0;
            lead_reg   <= '0;
            acc_reg    <= '0;
            seq_reg    <= '0;
            off_reg    <= '0;
            cw_reg     <= '0;
            cc_reg     <= '0;
            resume_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            lead_reg   <= lead_next;
            acc_reg    <= acc_next;
            seq_reg    <= seq_next;
            off_reg    <= off_next;
            cw_reg     <= cw_next;
            cc_reg     <= cc_next;
            resume_reg <= resume_next;
        end
    end

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.done_res |=> phase_reg == PH_WRITING && off_reg == '0)
        else $error("string end did not clear decoder state");

    a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.status == ST_ERROR && !res.done_res
        |=> phase_reg == PH_DISCARD)
        else $error("error inside string did not enter discard");

    a_pend_le_lead: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= lead_reg)
        else $error("pending count exceeds sequence length");

    a_full_mode: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.status == ST_FULL |-> !cfg.count_when_full
        ##1 phase_reg == PH_DISCARD)
        else $error("full stop in count mode or without discard");

endmodule

// ----- hw/rtl/utf8_to_utf32_decoder_unit.sv -----
// Top level of the UTF-8 to UTF-32 decoder: config, input and output registers.
//
// Channels: "bytes" takes one UTF-8 byte per beat (in_byte, is_last); "chars"
// delivers at most one result per byte (code_point, status, count, offset,
// done_res); "cfg" writes stop_at_nul (index 0), out_limit (1) and
// count_when_full (2) and is always ready. Write config only while idle.
// A byte taken into the input register is decoded as it advances; its result,
// if any, is loaded into the output register and shown from then on.
// Throughput: one byte per cycle while the output is not stalled; the decode and
// the counter add/compare on the COUNT_BITS-wide counters sit between the input
// and output registers. Bytes that make no result (leading and middle bytes of a
// sequence, bytes discarded after an error or full stop) still take a step each.
// Reset: registers return to stop_at_nul 1, out_limit 0, count_when_full 0,
// and the decoder starts a new string. When the receiver stalls, the output
// register holds its beat, the input register fills, and then bytes.ready
// drops until a result is taken.
module utf8_to_utf32_decoder_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    u8d_in_if.sink    bytes,
    u8d_out_if.source chars,
    u8d_cfg_if.sink   cfg
);
    import u8d_pkg::*;

    cfg_t        cfg_reg;
    logic        in_vld_reg;
    item_t       in_item_reg;
    logic        out_vld_reg;
    res_t        out_res_reg;
    res_t        res;
    logic        advance;

    assign advance     = in_vld_reg && (!out_vld_reg || chars.ready);
    assign bytes.ready = !in_vld_reg || advance;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_at_nul     <= 1'b1;
            cfg_reg.out_limit       <= '0;
            cfg_reg.count_when_full <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_STOP_AT_NUL:     cfg_reg.stop_at_nul     <= cfg.data[0];
                CFG_OUT_LIMIT:       cfg_reg.out_limit       <= cfg.data;
                CFG_COUNT_WHEN_FULL: cfg_reg.count_when_full <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (bytes.ready)
            in_vld_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_item_reg.in_byte <= bytes.in_byte;
            in_item_reg.is_last <= bytes.is_last;
        end
    end

    u8d_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // Output register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= res.valid;
        else if (chars.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
            out_res_reg <= res;
    end

    assign chars.valid      = out_vld_reg;
    assign chars.code_point = out_res_reg.code_point;
    assign chars.status     = out_res_reg.status;
    assign chars.count      = out_res_reg.count;
    assign chars.offset     = out_res_reg.offset;
    assign chars.done_res   = out_res_reg.done_res;

endmodule
